/* sv/bm25ps_pkg.sv */
// Shared widths, constants and controller command bundle for the BM25 posting scorer.
// No dependencies; imported by the controller, datapath and top level.
package bm25ps_pkg;

    localparam int TfW     = 16;
    localparam int DlenW   = 24;
    localparam int IdfW    = 21;
    localparam int AvgW    = 16;
    localparam int ScoreW  = 23;
    localparam int CfgIdxW = 1;

    localparam int ProdW   = TfW + AvgW;          // f * avgdl
    localparam int Dl3W    = DlenW + 2;           // 3 * dlen
    localparam int NumPW   = IdfW + ProdW;        // idf * f * avgdl
    localparam int NumW    = NumPW + 3;           // 6 * idf * f * avgdl
    localparam int DenW    = ProdW + 2;           // 2*f*avgdl + avgdl + 3*dlen
    localparam int QuoW    = ScoreW + 1;          // one extra bit flags saturation
    localparam int DivW    = DenW + ScoreW;       // divisor aligned to top quotient bit
    localparam int CntW    = $clog2(QuoW);

    localparam logic [IdfW-1:0]    IdfReset   = IdfW'(65536);
    localparam logic [AvgW-1:0]    AvgReset   = AvgW'(130);
    localparam logic [ScoreW-1:0]  ScoreMax   = {ScoreW{1'b1}};
    localparam logic [CfgIdxW-1:0] CfgIdfIdx  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgAvgIdx  = CfgIdxW'(1);

    typedef struct packed {
        logic capture;    // latch input, form f*avgdl and 3*dlen
        logic mul_stage;  // form idf product and divisor
        logic div_init;   // load remainder and aligned divisor
        logic div_step;   // one restoring quotient bit
        logic retire;     // write output register, update running max
    } ctrl_cmd_t;

endpackage

/* sv/bm25ps_ctrl.sv */
// Controller FSM for the BM25 posting scorer: sequences capture, multiply,
// divide and retire, and owns both stream handshakes. Depends on bm25ps_pkg.
module bm25ps_ctrl import bm25ps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t cmd
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StMul  = 3'd1;
    localparam logic [2:0] StLoad = 3'd2;
    localparam logic [2:0] StDiv  = 3'd3;
    localparam logic [2:0] StDone = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == StIdle);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        case (state_reg)
            StIdle: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = StMul;
                end
            end
            StMul: begin
                cmd.mul_stage = 1'b1;
                state_next    = StLoad;
            end
            StLoad: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = StDiv;
            end
            StDiv: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(QuoW - 1)) begin
                    state_next = StDone;
                end
            end
            StDone: begin
                if (out_free) begin
                    cmd.retire     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = StIdle;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= StIdle;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/bm25ps_dp.sv */
// Datapath for the BM25 posting scorer: config registers, two multiply stages,
// a restoring divider and the running list maximum. Depends on bm25ps_pkg.
module bm25ps_dp import bm25ps_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [IdfW-1:0]    cfg_wr_data,
    input  logic [TfW-1:0]     term_frequency,
    input  logic [DlenW-1:0]   doc_length,
    input  logic               list_end,
    input  ctrl_cmd_t          cmd,
    output logic [ScoreW-1:0]  score,
    output logic [ScoreW-1:0]  list_max,
    output logic               final_flag
);

    logic [IdfW-1:0]   idf_reg;
    logic [AvgW-1:0]   avg_reg;
    logic [AvgW-1:0]   avg_eff;
    logic [ProdW-1:0]  prod_reg;
    logic [Dl3W-1:0]   dl3_reg;
    logic              last_reg;
    logic [NumPW-1:0]  nump_reg;
    logic [DenW-1:0]   den_reg;
    logic [NumW-1:0]   rem_reg;
    logic [DivW-1:0]   dsh_reg;
    logic [QuoW-1:0]   quo_reg;
    logic [ScoreW-1:0] run_max_reg;
    logic [ScoreW-1:0] score_reg, max_reg;
    logic              final_reg;

    logic [DivW-1:0]   rem_ext;
    logic              rem_ge;
    logic [ScoreW-1:0] score_next, max_next;

    // avgdl of zero is treated as one so the divisor never vanishes
    assign avg_eff = (avg_reg == '0) ? AvgW'(1) : avg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idf_reg <= IdfReset;
            avg_reg <= AvgReset;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CfgIdfIdx: idf_reg <= cfg_wr_data;
                CfgAvgIdx: avg_reg <= cfg_wr_data[AvgW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            prod_reg <= ProdW'(term_frequency) * ProdW'(avg_eff);
            dl3_reg  <= {2'b00, doc_length} + {1'b0, doc_length, 1'b0};
            last_reg <= list_end;
        end
        if (cmd.mul_stage) begin
            nump_reg <= NumPW'(idf_reg) * NumPW'(prod_reg);
            den_reg  <= {1'b0, prod_reg, 1'b0} + DenW'(avg_eff) + DenW'(dl3_reg);
        end
    end

    // restoring division, MSB first; the first bit set means quotient >= 2^23
    assign rem_ext = DivW'(rem_reg);
    assign rem_ge  = (rem_ext >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= {1'b0, nump_reg, 2'b00} + {2'b00, nump_reg, 1'b0};
            dsh_reg <= {den_reg, {ScoreW{1'b0}}};
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_ge) begin
                rem_reg <= NumW'(rem_ext - dsh_reg);
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QuoW-2:0], rem_ge};
        end
    end

    assign score_next = quo_reg[QuoW-1] ? ScoreMax : quo_reg[ScoreW-1:0];
    assign max_next   = (score_next > run_max_reg) ? score_next : run_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_max_reg <= '0;
        end else if (cmd.retire) begin
            run_max_reg <= last_reg ? '0 : max_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.retire) begin
            score_reg <= score_next;
            max_reg   <= max_next;
            final_reg <= last_reg;
        end
    end

    assign score      = score_reg;
    assign list_max   = max_reg;
    assign final_flag = final_reg;

endmodule

/* sv/bm25_posting_scorer.sv */
// BM25 posting scorer, k1 = 2 and b = 0.75; idf_weight and score are Q16 fixed point.
// Top level: joins bm25ps_ctrl and bm25ps_dp. Depends on bm25ps_pkg.
//
// One posting per transfer: score = floor(idf*6*f*avgdl / (2*f*avgdl + avgdl + 3*dlen)),
// saturated at 2^23-1, plus the running list maximum, which clears after the
// transfer marked by s_tlast. Each item takes these steps in order: the input transfer,
// which captures the posting and forms f*avgdl, the idf multiply, the divider load, the
// one-bit-per-cycle restoring divider over 24 quotient bits, and the output register
// write, which waits until that register is free; m_tvalid rises once it is written.
// The next item can be accepted once the previous result is registered, even if that
// result is still waiting on m_tready. idf_weight (index 0) and avg_doc_length
// (index 1) are written through cfg_wr_en/cfg_index/cfg_wr_data; the user must write
// them only while the block is idle, as the block itself does not enforce this.
module bm25_posting_scorer import bm25ps_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [IdfW-1:0]    cfg_wr_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,   // term_frequency[15:0], doc_length[39:16]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,   // score[22:0], list_max[45:23], zero[47:46]
    output logic               m_tlast
);

    ctrl_cmd_t         cmd;
    logic [ScoreW-1:0] score, list_max;

    bm25ps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bm25ps_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .term_frequency (s_tdata[TfW-1:0]),
        .doc_length     (s_tdata[TfW+DlenW-1:TfW]),
        .list_end       (s_tlast),
        .cmd            (cmd),
        .score          (score),
        .list_max       (list_max),
        .final_flag     (m_tlast)
    );

    assign m_tdata = {2'b00, list_max, score};

endmodule
